// ===== design/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the stepper shuttle sequencer
// Transaction payloads, configuration record, register indexes and reset
// values of the configuration registers.
// ----------------------------------------------------------------------------
package sss_pkg;

	// default widths of the position counter and of the millisecond timer
	localparam int POS_BITS_DEF  = 16;
	localparam int TIME_BITS_DEF = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STOP_DISTANCE  = 3'd0,
		REG_CLEAR_DISTANCE = 3'd1,
		REG_CLEAR_COUNT    = 3'd2,
		REG_MID_POSITION   = 3'd3,
		REG_END_POSITION   = 3'd4,
		REG_DWELL_MS       = 3'd5
	} reg_idx_t;

	// configuration reset values
	localparam logic [15:0] STOP_DISTANCE_RST  = 16'd30;
	localparam logic [15:0] CLEAR_DISTANCE_RST = 16'd50;
	localparam logic [3:0]  CLEAR_COUNT_RST    = 4'd5;
	localparam logic [15:0] MID_POSITION_RST   = 16'd2828;
	localparam logic [15:0] END_POSITION_RST   = 16'd5650;
	localparam logic [31:0] DWELL_MS_RST       = 32'd2000;

	// request kinds
	localparam logic REQ_POLL = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// indicator lamp codes
	typedef enum logic [1:0] {
		LAMP_OFF    = 2'd0,
		LAMP_RED    = 2'd1,
		LAMP_GREEN  = 2'd2,
		LAMP_YELLOW = 2'd3
	} lamp_t;

	typedef struct packed {
		logic [15:0] stop_distance;
		logic [15:0] clear_distance;
		logic [3:0]  clear_count;
		logic [15:0] mid_position;
		logic [15:0] end_position;
		logic [31:0] dwell_ms;
	} sss_cfg_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] distance_mm;
		logic        right_limit;
		logic        left_limit;
		logic        start_request;
		logic [31:0] now_ms;
	} sss_cmd_t;

	typedef struct packed {
		logic        pulse_enable;
		logic        move_forward;
		logic [1:0]  lamp_color;
		logic        report_strobe;
		logic [3:0]  phase;
		logic [15:0] step_position;
		logic        halted_by_obstacle;
	} sss_res_t;

endpackage

// ===== design/sss_stream_if.sv =====
// ----------------------------------------------------------------------------
// sss_stream_if: valid/ready channel
// Carries one payload of type T per transaction; a transaction completes at a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface sss_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/stepper_shuttle_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepper_shuttle_sequencer: shuttle run sequencer for a stepper drive
//
// Channels: cmd (sink) takes poll and step-pulse transactions, res (source)
// returns exactly one result transaction for each, in order. The user must
// write configuration registers through cfg_we / cfg_idx / cfg_wdata only
// while the block is idle, not enforced by it; unknown indexes are ignored.
// A cmd transaction goes through the input register, then the result register.
// Throughput: one transaction per clock while res is taken; the input
// register, the sequencer logic and the result register form a two-stage
// path, and the sequencer state is updated in the same cycle the result is
// registered, so the next transaction sees it at once.
// Reset (arst_n low): both stages empty, sequencer back to homing start at
// position 0, direction forward, lamp off, configuration to defaults.
// Stall: when res is not taken, the result register holds, one further
// transaction waits in the input register, and cmd.ready drops.
// ----------------------------------------------------------------------------
module stepper_shuttle_sequencer #(
	parameter int POS_BITS  = sss_pkg::POS_BITS_DEF,
	parameter int TIME_BITS = sss_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sss_stream_if.sink                      cmd,
	sss_stream_if.source                    res,
	input  logic                            cfg_we,
	input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sss_pkg::*;

	sss_cfg_t cfg;
	sss_cmd_t item_s1;
	logic     valid_s1;
	sss_res_t result;
	sss_res_t res_data_s2;
	logic     res_valid_s2;
	logic     advance;
	logic     take_in;

	sss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sss_seq_core #(
		.POS_BITS  (POS_BITS),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// move stage 1 forward whenever the result register is free or drains
	assign advance   = valid_s1 && (!res_valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign take_in   = cmd.valid && cmd.ready;

	assign res.valid = res_valid_s2;
	assign res.data  = res_data_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			item_s1 <= cmd.data;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_data_s2 <= result;
	end

endmodule

// ===== design/sss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sss_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port, reset to defaults.
// ----------------------------------------------------------------------------
module sss_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sss_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output sss_pkg::sss_cfg_t                cfg
);
	import sss_pkg::*;

	sss_cfg_t cfg_q;

	assign cfg = cfg_q;

	// load the addressed register, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_distance  <= STOP_DISTANCE_RST;
			cfg_q.clear_distance <= CLEAR_DISTANCE_RST;
			cfg_q.clear_count    <= CLEAR_COUNT_RST;
			cfg_q.mid_position   <= MID_POSITION_RST;
			cfg_q.end_position   <= END_POSITION_RST;
			cfg_q.dwell_ms       <= DWELL_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STOP_DISTANCE:  cfg_q.stop_distance  <= cfg_wdata[15:0];
				REG_CLEAR_DISTANCE: cfg_q.clear_distance <= cfg_wdata[15:0];
				REG_CLEAR_COUNT:    cfg_q.clear_count    <= cfg_wdata[3:0];
				REG_MID_POSITION:   cfg_q.mid_position   <= cfg_wdata[15:0];
				REG_END_POSITION:   cfg_q.end_position   <= cfg_wdata[15:0];
				REG_DWELL_MS:       cfg_q.dwell_ms       <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/sss_seq_core.sv =====
// ----------------------------------------------------------------------------
// sss_seq_core: sequencer state and next-state logic
// Computes the result of one transaction from the current state and commits
// the new state when the transaction is taken.
// ----------------------------------------------------------------------------
module sss_seq_core #(
	parameter int POS_BITS  = sss_pkg::POS_BITS_DEF,
	parameter int TIME_BITS = sss_pkg::TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  sss_pkg::sss_cmd_t  item,
	input  sss_pkg::sss_cfg_t  cfg,
	output sss_pkg::sss_res_t  result
);
	import sss_pkg::*;

	typedef enum logic [3:0] {
		PH_HOME_START     = 4'd0,
		PH_HOMING         = 4'd1,
		PH_WAIT_START     = 4'd2,
		PH_GO_MID         = 4'd3,
		PH_TO_MID         = 4'd4,
		PH_DWELL_MID      = 4'd5,
		PH_TO_END         = 4'd6,
		PH_DWELL_END      = 4'd7,
		PH_BACK_MID       = 4'd8,
		PH_DWELL_BACK_MID = 4'd9,
		PH_BACK_ZERO      = 4'd10,
		PH_DWELL_ORIGIN   = 4'd11
	} phase_t;

	localparam logic [3:0] SAFE_MAX = 4'd15;

	phase_t                 phase_q,          phase_n;
	logic [POS_BITS-1:0]    pos_q,            pos_n;
	logic                   dir_fwd_q,        dir_fwd_n;
	logic                   pulses_q,         pulses_n;
	logic                   hold_q,           hold_n;
	logic [3:0]             safe_run_q,       safe_run_n;
	logic [TIME_BITS-1:0]   obstacle_since_q, obstacle_since_n;
	logic [TIME_BITS-1:0]   dwell_since_q,    dwell_since_n;
	lamp_t                  lamp_q,           lamp_n;
	logic                   report;

	logic [TIME_BITS-1:0]   now_t;
	logic [31:0]            pos_wide;
	logic [31:0]            mid_wide;
	logic [31:0]            end_wide;
	logic                   dwell_done;

	assign now_t    = item.now_ms[TIME_BITS-1:0];
	assign mid_wide = {16'd0, cfg.mid_position};
	assign end_wide = {16'd0, cfg.end_position};

	// next state of one transaction
	always_comb begin
		phase_n          = phase_q;
		pos_n            = pos_q;
		dir_fwd_n        = dir_fwd_q;
		pulses_n         = pulses_q;
		hold_n           = hold_q;
		safe_run_n       = safe_run_q;
		obstacle_since_n = obstacle_since_q;
		dwell_since_n    = dwell_since_q;
		lamp_n           = lamp_q;
		report           = 1'b0;
		pos_wide         = 32'(pos_q);
		dwell_done       = 1'b0;

		if (item.req_type == REQ_STEP) begin
			// count the emitted pulse, saturate at the top, hold at zero
			if (dir_fwd_q) begin
				if (pos_q != {POS_BITS{1'b1}})
					pos_n = pos_q + 1'b1;
			end else if (pos_q != '0) begin
				pos_n = pos_q - 1'b1;
			end
		end else begin
			// enter the obstacle hold
			if (item.distance_mm != 16'd0 && item.distance_mm <= cfg.stop_distance
				&& !hold_q) begin
				pulses_n         = 1'b0;
				hold_n           = 1'b1;
				safe_run_n       = 4'd0;
				obstacle_since_n = now_t;
				lamp_n           = LAMP_RED;
			end

			// count safe readings and release the hold
			if (hold_n) begin
				if (item.distance_mm >= cfg.clear_distance) begin
					if (safe_run_n < SAFE_MAX)
						safe_run_n = safe_run_n + 4'd1;
				end else begin
					safe_run_n = 4'd0;
				end
				if (safe_run_n >= cfg.clear_count) begin
					dwell_since_n = dwell_since_n + (now_t - obstacle_since_n);
					if (phase_n inside {PH_HOMING, PH_TO_MID, PH_TO_END, PH_BACK_MID,
						PH_BACK_ZERO}) begin
						pulses_n = 1'b1;
						lamp_n   = LAMP_GREEN;
					end else begin
						lamp_n = LAMP_YELLOW;
					end
					hold_n     = 1'b0;
					safe_run_n = 4'd0;
				end
			end

			pos_wide   = 32'(pos_n);
			dwell_done = 32'(now_t - dwell_since_n) > cfg.dwell_ms;

			// advance the run sequence
			if (!hold_n) begin
				unique case (phase_q)
					PH_HOME_START: begin
						if (!item.right_limit) begin
							dir_fwd_n = 1'b0;
							pulses_n  = 1'b1;
						end
						phase_n = PH_HOMING;
					end
					PH_HOMING: begin
						if (item.right_limit) begin
							pulses_n = 1'b0;
							pos_n    = '0;
							phase_n  = PH_WAIT_START;
						end
					end
					PH_WAIT_START: begin
						if (item.start_request) begin
							pos_n   = '0;
							phase_n = PH_GO_MID;
						end
					end
					PH_GO_MID: begin
						dir_fwd_n = 1'b1;
						pulses_n  = 1'b1;
						phase_n   = PH_TO_MID;
					end
					PH_TO_MID: begin
						if (pos_wide >= mid_wide) begin
							pulses_n      = 1'b0;
							lamp_n        = LAMP_YELLOW;
							dwell_since_n = now_t;
							phase_n       = PH_DWELL_MID;
						end
					end
					PH_DWELL_MID: begin
						if (dwell_done) begin
							report    = 1'b1;
							lamp_n    = LAMP_GREEN;
							dir_fwd_n = 1'b1;
							pulses_n  = 1'b1;
							phase_n   = PH_TO_END;
						end
					end
					PH_TO_END: begin
						if (pos_wide >= end_wide || item.left_limit) begin
							pulses_n      = 1'b0;
							lamp_n        = LAMP_YELLOW;
							dwell_since_n = now_t;
							phase_n       = PH_DWELL_END;
						end
					end
					PH_DWELL_END: begin
						if (dwell_done) begin
							report    = 1'b1;
							lamp_n    = LAMP_GREEN;
							dir_fwd_n = 1'b0;
							pulses_n  = 1'b1;
							phase_n   = PH_BACK_MID;
						end
					end
					PH_BACK_MID: begin
						if (pos_wide <= mid_wide) begin
							pulses_n      = 1'b0;
							lamp_n        = LAMP_YELLOW;
							dwell_since_n = now_t;
							phase_n       = PH_DWELL_BACK_MID;
						end
					end
					PH_DWELL_BACK_MID: begin
						if (dwell_done) begin
							report    = 1'b1;
							lamp_n    = LAMP_GREEN;
							dir_fwd_n = 1'b0;
							pulses_n  = 1'b1;
							phase_n   = PH_BACK_ZERO;
						end
					end
					PH_BACK_ZERO: begin
						if (pos_n == '0 || item.right_limit) begin
							pos_n         = '0;
							pulses_n      = 1'b0;
							lamp_n        = LAMP_YELLOW;
							dwell_since_n = now_t;
							phase_n       = PH_DWELL_ORIGIN;
						end
					end
					PH_DWELL_ORIGIN: begin
						if (dwell_done) begin
							report  = 1'b1;
							lamp_n  = LAMP_GREEN;
							phase_n = PH_GO_MID;
						end
					end
					default: phase_n = PH_HOME_START;
				endcase
			end
		end
	end

	// present the post-transaction state
	always_comb begin
		result.pulse_enable       = pulses_n;
		result.move_forward       = dir_fwd_n;
		result.lamp_color         = lamp_n;
		result.report_strobe      = report;
		result.phase              = phase_n;
		result.step_position      = 16'(pos_n);
		result.halted_by_obstacle = hold_n;
	end

	// commit the state on a taken transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HOME_START;
			pos_q            <= '0;
			dir_fwd_q        <= 1'b1;
			pulses_q         <= 1'b0;
			hold_q           <= 1'b0;
			safe_run_q       <= 4'd0;
			obstacle_since_q <= '0;
			dwell_since_q    <= '0;
			lamp_q           <= LAMP_OFF;
		end else if (fire) begin
			phase_q          <= phase_n;
			pos_q            <= pos_n;
			dir_fwd_q        <= dir_fwd_n;
			pulses_q         <= pulses_n;
			hold_q           <= hold_n;
			safe_run_q       <= safe_run_n;
			obstacle_since_q <= obstacle_since_n;
			dwell_since_q    <= dwell_since_n;
			lamp_q           <= lamp_n;
		end
	end

endmodule
